/* hdl/xmlesc_pkg.sv */
// ----------------------------------------------------------------------------
// xmlesc_pkg
// Shared types, register codes and escape tables for the string escaper.
// ----------------------------------------------------------------------------
package xmlesc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_OUTPUT_MODE = 2'd0;
  localparam logic [1:0] CFG_XML_COMPAT  = 2'd1;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // output_mode codes
  localparam logic [2:0] MODE_STANDARD = 3'd0;
  localparam logic [2:0] MODE_LISP     = 3'd1;
  localparam logic [2:0] MODE_ENCODE   = 3'd2;
  localparam logic [2:0] MODE_CONCLINE = 3'd3;
  localparam logic [2:0] MODE_XML      = 3'd4;

  localparam int RUN_MAX = 6;
  localparam int IDX_W   = $clog2(RUN_MAX);
  localparam int LEN_W   = $clog2(RUN_MAX + 1);

  typedef enum logic [1:0] {
    STYLE_PLAIN,
    STYLE_LISP,
    STYLE_XML
  } style_t;

  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_BLANK = 8'h20;

  // Entities, left-justified in a six-byte word
  localparam logic [47:0] ENT_QUOT = "&quot;";
  localparam logic [47:0] ENT_APOS = "&apos;";
  localparam logic [47:0] ENT_LT   = {"&lt;", 16'h0000};
  localparam logic [47:0] ENT_GT   = {"&gt;", 16'h0000};
  localparam logic [47:0] ENT_AMP  = {"&amp;", 8'h00};

  function automatic style_t style_of(logic [2:0] mode, logic compat);
    style_t s;
    if (compat || mode == MODE_XML) begin
      s = STYLE_XML;
    end else if (mode == MODE_LISP) begin
      s = STYLE_LISP;
    end else begin
      s = STYLE_PLAIN;
    end
    return s;
  endfunction

  function automatic logic [LEN_W-1:0] run_len(style_t s, logic [7:0] b);
    logic [LEN_W-1:0] n;
    n = LEN_W'(1);
    unique case (s)
      STYLE_XML: begin
        if (b == CH_QUOT || b == CH_APOS) begin
          n = LEN_W'(6);
        end else if (b == CH_LT || b == CH_GT) begin
          n = LEN_W'(4);
        end else if (b == CH_AMP) begin
          n = LEN_W'(5);
        end
      end
      STYLE_LISP: begin
        if (b == CH_QUOT || b == CH_BSL) begin
          n = LEN_W'(4);
        end
      end
      default: n = LEN_W'(1);
    endcase
    return n;
  endfunction

  function automatic logic [7:0] run_byte(style_t s, logic [7:0] b, logic [IDX_W-1:0] k);
    logic [47:0] ent;
    logic [47:0] sh;
    logic [7:0]  o;
    ent = 48'h0;
    o   = b;
    unique case (s)
      STYLE_XML: begin
        priority if (b == CH_QUOT) ent = ENT_QUOT;
        else if (b == CH_APOS) ent = ENT_APOS;
        else if (b == CH_LT)   ent = ENT_LT;
        else if (b == CH_GT)   ent = ENT_GT;
        else if (b == CH_AMP)  ent = ENT_AMP;
        else ent = 48'h0;
        sh = ent << {k, 3'b000};
        if (ent != 48'h0) begin
          o = sh[47:40];
        end else if (b >= 8'd1 && b <= 8'd31) begin
          o = CH_BLANK;
        end
      end
      STYLE_LISP: begin
        sh = 48'h0;
        if ((b == CH_QUOT || b == CH_BSL) && k != IDX_W'(3)) begin
          o = CH_BSL;
        end
      end
      default: begin
        sh = 48'h0;
        o  = b;
      end
    endcase
    return o;
  endfunction

endpackage

/* hdl/xml_lisp_string_escaper.sv */
// ----------------------------------------------------------------------------
// xml_lisp_string_escaper
// Streaming byte escaper: XML entities or Lisp backslash escapes per byte.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake             payload
//  in       in   in_valid/in_ready     in_byte[7:0], in_string_end
//  out      out  out_valid/out_ready   out_byte[7:0], out_run_last, out_string_done
//  cfg      in   cfg_valid/cfg_ready   cfg_index[1:0], cfg_data[7:0]
//
//  One output byte per cycle while out_ready is high. A byte that maps to a
//  single output byte frees the run stage as it loads, so unstalled plain text
//  streams at one transaction per cycle; an entity of n bytes holds the input
//  until its last byte moves into the one-byte-wide output register. Reset
//  (synchronous, rst_n low) empties both stages and clears the registers to
//  standard mode. A stalled output holds its register and the run stage; a new
//  input is taken as the run's last byte loads. cfg_ready is always high.
//
module xml_lisp_string_escaper (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_byte,
  input  logic                             in_string_end,

  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_byte,
  output logic                             out_run_last,
  output logic                             out_string_done,

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [xmlesc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [xmlesc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic [2:0] mode_r;
  logic       compat_r;

  // Run stage: the input byte being expanded and its position in the run
  logic                          stg_valid_r;
  logic [7:0]                    stg_byte_r;
  logic                          stg_end_r;
  logic [xmlesc_pkg::IDX_W-1:0]  stg_idx_r;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_done_r;

  xmlesc_pkg::style_t              style;
  logic [xmlesc_pkg::LEN_W-1:0]    len;
  logic                            is_last;
  logic                            load;
  logic [7:0]                      byte_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= xmlesc_pkg::MODE_STANDARD;
      compat_r <= 1'b0;
    end else if (cfg_valid) begin
      // Ignore writes beyond the register list
      if (cfg_index == xmlesc_pkg::CFG_OUTPUT_MODE) begin
        mode_r <= cfg_data[2:0];
      end else if (cfg_index == xmlesc_pkg::CFG_XML_COMPAT) begin
        compat_r <= cfg_data[0];
      end
    end
  end

  always_comb begin
    style    = xmlesc_pkg::style_of(mode_r, compat_r);
    len      = xmlesc_pkg::run_len(style, stg_byte_r);
    byte_nxt = xmlesc_pkg::run_byte(style, stg_byte_r, stg_idx_r);
    is_last  = (xmlesc_pkg::LEN_W'(stg_idx_r) == len - xmlesc_pkg::LEN_W'(1));
    // Move one run byte into the output register when it is free or draining
    load     = stg_valid_r && (!out_valid_r || out_ready);
    // Take a new byte when the stage is empty or hands off its last byte now
    in_ready = !stg_valid_r || (load && is_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      stg_idx_r   <= '0;
    end else begin
      if (in_valid && in_ready) begin
        stg_valid_r <= 1'b1;
        stg_idx_r   <= '0;
      end else if (load) begin
        if (is_last) begin
          stg_valid_r <= 1'b0;
        end
        stg_idx_r <= stg_idx_r + xmlesc_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r <= in_byte;
      stg_end_r  <= in_string_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_nxt;
      out_last_r <= is_last;
      out_done_r <= is_last && stg_end_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_run_last    = out_last_r;
  assign out_string_done = out_done_r;

`ifndef SYNTHESIS
  // A busy stage with a stalled output keeps its run position
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && !load |=> $stable(stg_idx_r))
    else $error("run position moved without a transfer");

  // A new input may only displace a stage that hands off its last byte
  a_take_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && stg_valid_r |-> load && is_last)
    else $error("input accepted while run unfinished");

  // The run position stays inside the run
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r |-> (xmlesc_pkg::LEN_W'(stg_idx_r) < len))
    else $error("run position past run length");

  // End of string marks only the last byte of a run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_last_r)
    else $error("string_done without run_last");
`endif

endmodule

/* sim/xml_lisp_string_escaper_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_lisp_string_escaper_checker
// Watches the config, input and output channels and predicts the escaped byte
// stream. It compares each output transaction against the oldest predicted
// byte and reports the running mismatch count and outstanding byte count.
// ----------------------------------------------------------------------------
module xml_lisp_string_escaper_checker
  import xmlesc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   in_string_end,

  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [7:0]             out_byte,
  input  logic                   out_run_last,
  input  logic                   out_string_done,

  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,

  output int                     mismatch_cnt,
  output int                     bytes_owed,
  output int                     bytes_seen
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       done;
  } esc_byte_t;

  esc_byte_t  escaped_bytes [$];
  esc_byte_t  want;
  logic [2:0] esc_mode;
  logic       esc_compat;
  int         fails;
  int         seen;

  assign mismatch_cnt = fails;
  assign bytes_seen   = seen;

  // Expand one raw character into its escaped run under the current style.
  function automatic void expand_char(input logic [7:0] b, input logic fin);
    logic [7:0] seq [$];
    string      ent;
    bit         xml_style;
    esc_byte_t  item;
    ent       = "";
    xml_style = esc_compat || (esc_mode == MODE_XML);
    if (xml_style) begin
      case (b)
        CH_QUOT: ent = "&quot;";
        CH_APOS: ent = "&apos;";
        CH_LT:   ent = "&lt;";
        CH_GT:   ent = "&gt;";
        CH_AMP:  ent = "&amp;";
        default: ent = "";
      endcase
      if (ent.len() != 0) begin
        for (int k = 0; k < ent.len(); k++) seq.push_back(ent[k]);
      end else if (b >= 8'd1 && b <= 8'd31) begin
        seq.push_back(CH_BLANK);
      end else begin
        seq.push_back(b);
      end
    end else if (esc_mode == MODE_LISP) begin
      if (b == CH_QUOT || b == CH_BSL) begin
        repeat (3) seq.push_back(CH_BSL);
      end
      seq.push_back(b);
    end else begin
      seq.push_back(b);
    end
    for (int k = 0; k < seq.size(); k++) begin
      item.data     = seq[k];
      item.run_last = (k == seq.size() - 1);
      item.done     = item.run_last ? fin : 1'b0;
      escaped_bytes.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      esc_mode   = MODE_STANDARD;
      esc_compat = 1'b0;
      escaped_bytes.delete();
      fails = 0;
      seen  = 0;
    end else begin
      // Retire output first: a byte leaving now was predicted earlier.
      if (out_valid && out_ready) begin
        seen++;
        if (escaped_bytes.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: unexpected output byte %02h last %b done %b",
                     $realtime, out_byte, out_run_last, out_string_done);
          end
        end else begin
          want = escaped_bytes.pop_front();
          if (out_byte !== want.data || out_run_last !== want.run_last ||
              out_string_done !== want.done) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: mismatch: expected byte %02h last %b done %b, got %02h %b %b",
                       $realtime, want.data, want.run_last, want.done,
                       out_byte, out_run_last, out_string_done);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        expand_char(in_byte, in_string_end);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OUTPUT_MODE: esc_mode   = cfg_data[2:0];
          CFG_XML_COMPAT:  esc_compat = cfg_data[0];
          default: ;
        endcase
      end
    end
    bytes_owed <= escaped_bytes.size();
  end

endmodule

/* sim/xml_lisp_string_escaper_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_lisp_string_escaper_tb
// Drives text strings through the escaper under every escape style, with
// random idle gaps on the input and random stalls on the output. A checker
// beside the block predicts each escaped byte; this top gives the verdict.
// ----------------------------------------------------------------------------
module xml_lisp_string_escaper_tb;
  import xmlesc_pkg::*;

  // Register indexes past the end of the map: writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;
  // Unnamed mode codes behave like plain pass-through
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int PHASES      = 8;
  localparam int PHASE_CHARS = 42;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             in_byte = 8'h00;
  logic                   in_string_end = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             out_byte;
  logic                   out_run_last;
  logic                   out_string_done;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int          mismatch_cnt;
  int          bytes_owed;
  int          bytes_seen;
  int          chars_sent;
  int          reg_writes;
  bit          quiet;        // no idling on either side while set
  int unsigned rx_wait;
  int unsigned rx_draw;

  always #5 clk = ~clk;

  xml_lisp_string_escaper dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_string_end   (in_string_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_string_done (out_string_done),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  xml_lisp_string_escaper_checker esc_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_string_end   (in_string_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_string_done (out_string_done),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_cnt    (mismatch_cnt),
    .bytes_owed      (bytes_owed),
    .bytes_seen      (bytes_seen)
  );

  // Output pacing: after every accepted transaction hold ready low for a random
  // stall, possibly none, then hold it high until the next byte leaves.
  // The stall can land in the middle of an entity run, at its last byte, or
  // between runs, so every phase of the run stage sees back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (rx_wait != 0) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else if (out_valid && out_ready) begin
      rx_draw   = quiet ? 0 : $urandom_range(0, 9);
      rx_wait   <= rx_draw;
      out_ready <= (rx_draw == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Send one character. Drop valid only when a gap is drawn, so a back-to-back
  // transaction never sees valid lowered and raised in the same time step.
  task automatic send_char(input logic [7:0] ch, input logic fin);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= ch;
    in_string_end <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  // Hold the input idle until every predicted byte has left the block.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (bytes_owed != 0);
  endtask

  // Register writes happen only with the block drained. Upper data bits are
  // random: the block must use only the low bits of each register.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_style(input logic [2:0] mode, input logic compat);
    logic [CFG_DATA_W-1:0] word;
    word      = CFG_DATA_W'($urandom);
    word[2:0] = mode;
    write_reg(CFG_OUTPUT_MODE, word);
    word      = CFG_DATA_W'($urandom);
    word[0]   = compat;
    write_reg(CFG_XML_COMPAT, word);
  endtask

  // Bias toward the characters that escape; keep a fair share of controls
  // and fully random bytes so every bit of the byte toggles.
  function automatic logic [7:0] pick_char();
    logic [7:0]  ch;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      case ($urandom_range(0, 6))
        0:       ch = CH_QUOT;
        1:       ch = CH_APOS;
        2:       ch = CH_LT;
        3:       ch = CH_GT;
        4:       ch = CH_AMP;
        5:       ch = CH_BSL;
        default: ch = 8'h00;
      endcase
    end else if (roll < 55) begin
      ch = 8'($urandom_range(1, 31));
    end else begin
      ch = 8'($urandom_range(0, 255));
    end
    return ch;
  endfunction

  // Limit: far beyond the slowest legal run (every character a six-byte
  // entity, every byte given the longest stall and every gap the longest).
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [2:0]  mode;
    logic        compat;
    int          len;
    int          sent;
    logic        fin;
    chars_sent = 0;
    reg_writes = 0;
    quiet      = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults to standard mode, so escapable characters
    // must pass through untouched.
    send_char(CH_QUOT, 1'b0);
    send_char(CH_BSL, 1'b1);
    settle();

    // XML style: all five entities, control range ends, byte zero, blank,
    // DEL and the high bytes that must pass unchanged.
    set_style(MODE_XML, 1'b0);
    send_char(CH_QUOT, 1'b0);
    send_char(CH_APOS, 1'b1);
    send_char(CH_LT, 1'b0);
    send_char(CH_GT, 1'b0);
    send_char(CH_AMP, 1'b1);
    send_char(8'h01, 1'b0);
    send_char(8'h1f, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h20, 1'b0);
    send_char(8'h7f, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h41, 1'b1);
    settle();

    // Lisp style: quote and backslash get three leading backslashes.
    set_style(MODE_LISP, 1'b0);
    send_char(CH_QUOT, 1'b0);
    send_char(CH_BSL, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(CH_LT, 1'b0);
    send_char(8'hff, 1'b1);
    settle();

    // Compat bit forces XML style out of standard mode.
    set_style(MODE_STANDARD, 1'b1);
    send_char(CH_QUOT, 1'b0);
    send_char(CH_AMP, 1'b0);
    send_char(8'h05, 1'b1);
    settle();

    // Highest mode code without compat behaves like plain mode; writes to
    // the unmapped indexes must leave the style alone.
    set_style(MODE_SPARE_HI, 1'b0);
    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
    send_char(CH_QUOT, 1'b1);
    settle();

    // Random phases: strings of random characters, each ending with the
    // end-of-string flag unless a rare flip drops it; flips also add stray flags.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin mode = MODE_STANDARD; compat = 1'b0; end
        1:       begin mode = MODE_LISP;     compat = 1'b0; end
        2:       begin mode = MODE_XML;      compat = 1'b0; end
        3:       begin mode = MODE_SPARE_HI; compat = 1'b0; end
        4:       begin mode = MODE_LISP;     compat = 1'b1; end
        5:       begin mode = MODE_ENCODE;   compat = 1'b1; end
        6:       begin mode = MODE_CONCLINE; compat = 1'b0; end
        default: begin
          mode   = 3'($urandom_range(0, 7));
          compat = 1'($urandom_range(0, 1));
          write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
          write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
        end
      endcase
      set_style(mode, compat);
      quiet = (p % 3 == 1);
      sent  = 0;
      while (sent < PHASE_CHARS) begin
        len = $urandom_range(1, 12);
        for (int j = 0; j < len; j++) begin
          fin = (j == len - 1);
          if ($urandom_range(0, 9) == 0) fin = ~fin;
          send_char(pick_char(), fin);
          sent++;
          // Drain completely once in the middle of phase 2
          if (p == 2 && sent == PHASE_CHARS / 2) settle();
        end
      end
      settle();
    end
    quiet = 1'b0;

    // Let any stray output show up before the verdict.
    repeat (20) @(posedge clk);

    $display("Covered %0d characters and %0d register writes over all escape styles;",
             chars_sent, reg_writes);
    $display("compared %0d escaped bytes, %0d mismatches, %0d still owed.",
             bytes_seen, mismatch_cnt, bytes_owed);
    if (mismatch_cnt == 0 && bytes_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/xmlesc_pkg.sv
hdl/xml_lisp_string_escaper.sv
sim/xml_lisp_string_escaper_checker.sv
sim/xml_lisp_string_escaper_tb.sv
